// ----- hw/rtl/hdbq_pkg.sv -----
// Shared widths, codes and types of the head-drop byte-bounded queue.
package hdbq_pkg;

  localparam int DEFAULT_DEPTH = 32;

  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int TAG_W     = 16;
  localparam int SIZE_W    = 24;
  localparam int STAMP_W   = 32;
  localparam int CNT_OUT_W = 6;
  localparam int ME_W      = 6;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Action codes of an input transfer
  localparam logic [ACT_W-1:0] ACT_PUT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_GET  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DROP = 2'd2;

  // Status codes of a result transfer
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_TOO_BIG = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;

  // Register indexes (paddr[2])
  localparam logic REG_MAX_ENTRIES = 1'b0;
  localparam logic REG_MAX_BYTES   = 1'b1;

  localparam logic [ME_W-1:0]   MAX_ENTRIES_RST = 6'd32;
  localparam logic [SIZE_W-1:0] MAX_BYTES_RST   = 24'd65536;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SIZE_W-1:0]  size;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [SIZE_W-1:0] a;
    logic [SIZE_W-1:0] b;
    logic              sub;
  } alu_req_t;

endpackage

// ----- hw/rtl/hdbq_if.sv -----
// Valid/ready channel interfaces for queue commands and queue results.
interface hdbq_in_if import hdbq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [TAG_W-1:0]   item_tag;
  logic [SIZE_W-1:0]  item_size;
  logic [STAMP_W-1:0] now;

  modport source (output valid, action, item_tag, item_size, now, input ready);
  modport sink   (input valid, action, item_tag, item_size, now, output ready);
endinterface

interface hdbq_out_if import hdbq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [CNT_OUT_W-1:0] drop_count;
  logic [TAG_W-1:0]     head_tag;
  logic [SIZE_W-1:0]    head_size;
  logic [STAMP_W-1:0]   head_time;
  logic [CNT_OUT_W-1:0] queue_length;
  logic [SIZE_W-1:0]    queue_bytes;

  modport source (output valid, status, drop_count, head_tag, head_size, head_time,
                  queue_length, queue_bytes, input ready);
  modport sink   (input valid, status, drop_count, head_tag, head_size, head_time,
                  queue_length, queue_bytes, output ready);
endinterface

// ----- hw/rtl/hdbq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hdbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/hdbq_alu.sv -----
// Shared byte adder/subtractor with a compare against the byte budget.
module hdbq_alu import hdbq_pkg::*; (
  input  alu_req_t          req,
  input  logic [SIZE_W-1:0] lim,
  output logic [SIZE_W:0]   res,
  output logic              over
);

  always_comb begin
    if (req.sub) begin
      res = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      res = {1'b0, req.a} + {1'b0, req.b};
    end
    over = res > {1'b0, lim};
  end

endmodule

// ----- hw/rtl/head_drop_byte_bounded_queue.sv -----
// Top level of the head-drop byte-bounded descriptor queue.
//
// Usage: commands arrive on in_ch (put, get head, drop head) and each one
// produces exactly one transfer on out_ch carrying status, drop count, the
// returned head entry (get only) and the queue length and byte total after
// the command. The user writes max_entries and max_bytes over the APB port
// only while it is idle, which the block does not enforce; pready is tied high.
//
// Sequence: commands are taken only in the idle state. A put without drops
// passes check, drop test and done; a get and a drop-head pass check, pop
// and done; a rejected put, a get or drop on an empty queue and the unused
// action code go from check to done. Each oldest entry dropped by a put adds
// a drop pop and a drop test: a read of the head size from the entry RAM and
// a pass through the shared adder/compare unit. Done returns to idle.
//
// Results sit in an output register, so the next command is taken while a
// result waits; the sequencer holds in its final state only while it is full.
//
// Reset (rst_n low, synchronous) empties the queue, clears the output valid and
// restores max_entries to 32 and max_bytes to 65536; the entry RAM is not cleared.
module head_drop_byte_bounded_queue import hdbq_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hdbq_in_if.sink               in_ch,
  hdbq_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > ME_W) ? CW : ME_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DROP_TEST, S_DROP_POP, S_POP, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [ME_W-1:0]   max_entries_r;
  logic [SIZE_W-1:0] max_bytes_r;
  logic              cfg_wr;

  // queue bookkeeping
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [SIZE_W-1:0] total_r, total_nxt;

  // latched command
  logic [ACT_W-1:0]   op_act_r, op_act_nxt;
  logic [TAG_W-1:0]   op_tag_r, op_tag_nxt;
  logic [SIZE_W-1:0]  op_size_r, op_size_nxt;
  logic [STAMP_W-1:0] op_now_r, op_now_nxt;

  // working result
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic [CNT_OUT_W-1:0] drops_r, drops_nxt;
  entry_t               hent_r, hent_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_status_r, out_status_nxt;
  logic [CNT_OUT_W-1:0] out_drops_r, out_drops_nxt;
  entry_t               out_hent_r, out_hent_nxt;
  logic [CNT_OUT_W-1:0] out_len_r, out_len_nxt;
  logic [SIZE_W-1:0]    out_bytes_r, out_bytes_nxt;

  // shared unit and RAM
  alu_req_t          alu_req;
  logic [SIZE_W:0]   alu_res;
  logic              alu_over;
  logic              ram_we;
  entry_t            ram_wdata;
  entry_t            ram_rdata;

  logic [EW-1:0]     count_ext;
  logic [EW-1:0]     me_ext;
  logic [EW-1:0]     entry_lim;
  logic [AW-1:0]     head_inc;
  logic [CW:0]       tail_sum;
  logic [AW-1:0]     tail;

  // --- configuration port -------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_MAX_ENTRIES: prdata = CFG_DATA_W'(max_entries_r);
      REG_MAX_BYTES:   prdata = CFG_DATA_W'(max_bytes_r);
    endcase
  end

  // --- address and limit arithmetic ---------------------------------------
  assign count_ext = EW'(count_r);
  assign me_ext    = EW'(max_entries_r);

  // An entry limit of zero acts as one; any limit above the depth acts as the depth.
  always_comb begin
    if (max_entries_r == '0) begin
      entry_lim = EW'(1);
    end else if (me_ext > EW'(DEPTH)) begin
      entry_lim = EW'(DEPTH);
    end else begin
      entry_lim = me_ext;
    end
  end

  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  // Tail is head + count wrapped once at the depth.
  always_comb begin
    tail_sum = (CW + 1)'(head_r) + (CW + 1)'(count_r);
    if (tail_sum >= (CW + 1)'(DEPTH)) begin
      tail_sum = tail_sum - (CW + 1)'(DEPTH);
    end
    tail = tail_sum[AW-1:0];
  end

  assign ram_wdata = '{tag: op_tag_r, size: op_size_r, stamp: op_now_r};

  hdbq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  hdbq_alu u_alu (
    .req  (alu_req),
    .lim  (max_bytes_r),
    .res  (alu_res),
    .over (alu_over)
  );

  // --- sequencer ----------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    op_act_nxt     = op_act_r;
    op_tag_nxt     = op_tag_r;
    op_size_nxt    = op_size_r;
    op_now_nxt     = op_now_r;
    status_nxt     = status_r;
    drops_nxt      = drops_r;
    hent_nxt       = hent_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_drops_nxt  = out_drops_r;
    out_hent_nxt   = out_hent_r;
    out_len_nxt    = out_len_r;
    out_bytes_nxt  = out_bytes_r;
    alu_req        = '{a: total_r, b: op_size_r, sub: 1'b0};
    ram_we         = 1'b0;

    // The receiver took the pending result.
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_act_nxt  = in_ch.action;
          op_tag_nxt  = in_ch.item_tag;
          op_size_nxt = in_ch.item_size;
          op_now_nxt  = in_ch.now;
          status_nxt  = ST_OK;
          drops_nxt   = '0;
          hent_nxt    = '0;
          state_nxt   = S_CHECK;
        end
      end

      S_CHECK: begin
        // size against the budget: 0 + size > max_bytes
        alu_req.a = '0;
        unique case (op_act_r)
          ACT_PUT: begin
            if (alu_over) begin
              status_nxt = ST_TOO_BIG;
              state_nxt  = S_DONE;
            end else begin
              state_nxt  = S_DROP_TEST;
            end
          end
          ACT_GET, ACT_DROP: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              state_nxt  = S_POP;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_DROP_TEST: begin
        // queue not empty and total + size > max_bytes, or the entry limit reached: drop the head
        if (count_r != '0 && (count_ext >= entry_lim || alu_over)) begin
          state_nxt = S_DROP_POP;
        end else begin
          ram_we    = 1'b1;
          count_nxt = count_r + CW'(1);
          total_nxt = alu_res[SIZE_W-1:0];
          state_nxt = S_DONE;
        end
      end

      S_DROP_POP: begin
        alu_req   = '{a: total_r, b: ram_rdata.size, sub: 1'b1};
        total_nxt = alu_res[SIZE_W-1:0];
        head_nxt  = head_inc;
        count_nxt = count_r - CW'(1);
        if (drops_r != '1) begin
          drops_nxt = drops_r + CNT_OUT_W'(1);
        end
        state_nxt = S_DROP_TEST;
      end

      S_POP: begin
        alu_req   = '{a: total_r, b: ram_rdata.size, sub: 1'b1};
        total_nxt = alu_res[SIZE_W-1:0];
        head_nxt  = head_inc;
        count_nxt = count_r - CW'(1);
        if (op_act_r == ACT_GET) begin
          hent_nxt = ram_rdata;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_drops_nxt  = drops_r;
          out_hent_nxt   = hent_r;
          out_len_nxt    = count_ext[CNT_OUT_W-1:0];
          out_bytes_nxt  = total_r;
          state_nxt      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= '0;
      count_r       <= '0;
      total_r       <= '0;
      out_valid_r   <= 1'b0;
      max_entries_r <= MAX_ENTRIES_RST;
      max_bytes_r   <= MAX_BYTES_RST;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_MAX_ENTRIES: max_entries_r <= pwdata[ME_W-1:0];
          REG_MAX_BYTES:   max_bytes_r   <= pwdata[SIZE_W-1:0];
        endcase
      end
    end
    op_act_r     <= op_act_nxt;
    op_tag_r     <= op_tag_nxt;
    op_size_r    <= op_size_nxt;
    op_now_r     <= op_now_nxt;
    status_r     <= status_nxt;
    drops_r      <= drops_nxt;
    hent_r       <= hent_nxt;
    out_status_r <= out_status_nxt;
    out_drops_r  <= out_drops_nxt;
    out_hent_r   <= out_hent_nxt;
    out_len_r    <= out_len_nxt;
    out_bytes_r  <= out_bytes_nxt;
  end

  // --- channel ports ------------------------------------------------------
  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.drop_count   = out_drops_r;
  assign out_ch.head_tag     = out_hent_r.tag;
  assign out_ch.head_size    = out_hent_r.size;
  assign out_ch.head_time    = out_hent_r.stamp;
  assign out_ch.queue_length = out_len_r;
  assign out_ch.queue_bytes  = out_bytes_r;

  // --- assertions ---------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> total_r == '0)
    else $error("empty queue holds bytes");

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_CHECK)
    else $error("accepted command not decoded");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> count_r == $past(count_r) + CW'(1))
    else $error("append did not grow the queue");

endmodule
